// ===== hw/rtl/asr_pkg.sv =====
// Shared constants and control/status types for the active set block.
`timescale 1ns / 1ps

package asr_pkg;

	localparam int MAX_ITEMS_DEF = 1024;

	localparam int ID_W    = 10;
	localparam int SLOT_W  = 10;
	localparam int COUNT_W = 11;
	localparam int IN_W    = 16;
	localparam int OUT_W   = 24;

	localparam logic ACT_ACTIVATE = 1'b0;
	localparam logic ACT_FINISH   = 1'b1;

	localparam logic [1:0] PHASE_FACTORIZE   = 2'd0;
	localparam logic [1:0] PHASE_PARENT_WAIT = 2'd1;
	localparam logic [1:0] PHASE_ASSEMBLE    = 2'd2;
	localparam logic [1:0] PHASE_NONE        = 2'd3;

	typedef struct packed {
		logic clear;
		logic capture;
		logic exec;
		logic fix;
	} asr_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic need_fix;
	} asr_sts_t;

endpackage

// ===== hw/rtl/asr_ctrl.sv =====
// Controller state machine: clearing pass, accept, execute, fix-up and output valid.
`timescale 1ns / 1ps

module asr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output asr_pkg::asr_cmd_t cmd,
	input  asr_pkg::asr_sts_t sts
);
	import asr_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_FIX   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.clear   = (state_q == ST_CLEAR);
		cmd.capture = (state_q == ST_IDLE) && s_tvalid;
		cmd.exec    = (state_q == ST_EXEC) && out_free;
		cmd.fix     = (state_q == ST_FIX);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (sts.clear_done) state_d = ST_IDLE;
			ST_IDLE:  if (s_tvalid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (out_free) state_d = sts.need_fix ? ST_FIX : ST_IDLE;
			end
			ST_FIX:   state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/asr_dp.sv =====
// Datapath: slot and inverse tables, active count, decision logic and result register.
`timescale 1ns / 1ps

module asr_dp #(
	parameter int MAX_ITEMS = asr_pkg::MAX_ITEMS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tuser,
	input  logic [asr_pkg::IN_W-1:0] s_tdata,
	output logic [asr_pkg::OUT_W-1:0] m_tdata,
	input  asr_pkg::asr_cmd_t        cmd,
	output asr_pkg::asr_sts_t        sts
);
	import asr_pkg::*;

	localparam int SW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [SW:0]      sot_mem [MAX_ITEMS];
	logic [ID_W-1:0]  iis_mem [MAX_ITEMS];

	logic             action_q, dense_q, push_q, xfer_q;
	logic [ID_W-1:0]  id_q;
	logic [SW:0]      sot_rd_q;
	logic [ID_W-1:0]  iis_rd_q;
	logic [CW-1:0]    count_q;
	logic [SW-1:0]    clr_q;
	logic [OUT_W-1:0] out_q;

	logic             id_ok, hit, full, act_new, fin_ok, fin_move;
	logic [SW-1:0]    pos, id_idx;
	logic             res_acc;
	logic [1:0]       res_phase;
	logic [SW-1:0]    res_slot;
	logic [CW-1:0]    count_d;

	logic             sot_we, iis_we;
	logic [SW-1:0]    sot_wa, iis_wa;
	logic [SW:0]      sot_wd;
	logic [ID_W-1:0]  iis_wd;

	assign id_ok  = (32'(id_q) < MAX_ITEMS);
	assign hit    = id_ok && sot_rd_q[SW];
	assign pos    = sot_rd_q[SW-1:0];
	assign id_idx = SW'(id_q);
	assign full   = (count_q == CW'(MAX_ITEMS));

	assign act_new  = (action_q == ACT_ACTIVATE) && id_ok && !hit && !full;
	assign fin_ok   = (action_q == ACT_FINISH) && hit && (push_q || xfer_q);
	assign fin_move = fin_ok && (count_q > CW'(1));

	assign sts.clear_done = (clr_q == SW'(MAX_ITEMS - 1));
	assign sts.need_fix   = fin_move && (iis_rd_q != id_q);

	always_comb begin
		res_acc   = 1'b1;
		res_phase = PHASE_NONE;
		res_slot  = '0;
		count_d   = count_q;
		if (action_q == ACT_ACTIVATE) begin
			if (!id_ok || (!hit && full)) begin
				res_acc = 1'b0;
			end else if (hit) begin
				res_slot = pos;
			end else begin
				res_slot = SW'(count_q);
				count_d  = count_q + CW'(1);
				if (dense_q) res_phase = PHASE_FACTORIZE;
				else if (push_q) res_phase = PHASE_PARENT_WAIT;
				else res_phase = PHASE_ASSEMBLE;
			end
		end else if (hit) begin
			res_slot = pos;
			if (fin_ok) count_d = count_q - CW'(1);
			else res_acc = 1'b0;
		end
	end

	always_comb begin
		sot_we = 1'b0;
		sot_wa = id_idx;
		sot_wd = '0;
		if (cmd.clear) begin
			sot_we = 1'b1;
			sot_wa = clr_q;
		end else if (cmd.exec && act_new) begin
			sot_we = 1'b1;
			sot_wd = {1'b1, SW'(count_q)};
		end else if (cmd.exec && fin_ok) begin
			sot_we = 1'b1;
		end else if (cmd.fix) begin
			sot_we = 1'b1;
			sot_wa = SW'(iis_rd_q);
			sot_wd = {1'b1, pos};
		end
	end

	always_comb begin
		iis_we = 1'b0;
		iis_wa = pos;
		iis_wd = iis_rd_q;
		if (cmd.exec && act_new) begin
			iis_we = 1'b1;
			iis_wa = SW'(count_q);
			iis_wd = id_q;
		end else if (cmd.exec && fin_move) begin
			iis_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sot_we) sot_mem[sot_wa] <= sot_wd;
		if (iis_we) iis_mem[iis_wa] <= iis_wd;
		if (cmd.capture) begin
			sot_rd_q <= sot_mem[SW'(s_tdata[ID_W-1:0])];
			iis_rd_q <= iis_mem[SW'(count_q - CW'(1))];
			action_q <= s_tuser;
			id_q     <= s_tdata[ID_W-1:0];
			dense_q  <= s_tdata[ID_W];
			push_q   <= s_tdata[ID_W+1];
			xfer_q   <= s_tdata[ID_W+2];
		end
		if (cmd.exec) begin
			out_q <= {COUNT_W'(count_d), SLOT_W'(res_slot), res_phase, res_acc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.exec) count_q <= count_d;
			if (cmd.clear) clr_q <= clr_q + SW'(1);
		end
	end

	assign m_tdata = out_q;

endmodule

// ===== hw/rtl/active_set_swap_remove.sv =====
// Top level of the active set with swap-remove: controller plus datapath.
//
//  channel  dir  signals                    transaction
//  s        in   s_tvalid s_tready s_tdata  one activate or finish request
//                s_tuser
//  m        out  m_tvalid m_tready m_tdata  one result per request
//
// A finish that moves the last id into the freed slot takes an extra fix-up
// state, as the slot-of-item table has a single write port. After reset a
// clearing pass over all MAX_ITEMS entries empties that table; s_tready
// stays low meanwhile. The result waits in an output register; a request
// in execution holds while that register is full and not taken.
`timescale 1ns / 1ps

module active_set_swap_remove #(
	parameter int MAX_ITEMS = asr_pkg::MAX_ITEMS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// item_id[9:0], is_dense[10], push_only[11], transfer_done[12], zero[15:13]
	input  logic [asr_pkg::IN_W-1:0]  s_tdata,
	// action[0]
	input  logic                      s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// accepted[0], initial_phase[2:1], slot[12:3], active_count[23:13]
	output logic [asr_pkg::OUT_W-1:0] m_tdata
);
	import asr_pkg::*;

	asr_cmd_t cmd;
	asr_sts_t sts;

	asr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	asr_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

// ===== tb/sv/tb_active_set_swap_remove.sv =====
// Self-checking testbench for active_set_swap_remove: directed and random set traffic.
`timescale 1ns / 1ps

module tb_active_set_swap_remove;
	import asr_pkg::*;

	localparam int NUM_IDS = MAX_ITEMS_DEF;
	localparam logic [COUNT_W-1:0] EMPTY_SLOT = COUNT_W'(NUM_IDS);

	typedef struct packed {
		logic              action;
		logic [ID_W-1:0]   item_id;
		logic              is_dense;
		logic              push_only;
		logic              transfer_done;
	} set_req_t;

	typedef struct packed {
		logic               accepted;
		logic [1:0]         initial_phase;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] active_count;
	} set_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	// shadow copy of the active set
	logic [COUNT_W-1:0] slot_of_id [NUM_IDS];
	logic [ID_W-1:0]    id_at_slot [NUM_IDS];
	int                 n_active;

	set_result_t pending_results [$];
	int          err_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	active_set_swap_remove #(
		.MAX_ITEMS(NUM_IDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_active_set_swap_remove: errors");
		$finish;
	end

	function automatic set_result_t apply_set_op(set_req_t r);
		set_result_t res;
		logic [COUNT_W-1:0] pos;
		logic [ID_W-1:0] mover;
		res.accepted = 1'b1;
		res.initial_phase = PHASE_NONE;
		res.slot = '0;
		if (r.action == ACT_ACTIVATE) begin
			if (slot_of_id[r.item_id] != EMPTY_SLOT) begin
				res.slot = slot_of_id[r.item_id][SLOT_W-1:0];
			end else if (n_active >= NUM_IDS) begin
				res.accepted = 1'b0;
			end else begin
				id_at_slot[n_active] = r.item_id;
				slot_of_id[r.item_id] = COUNT_W'(n_active);
				res.slot = SLOT_W'(n_active);
				n_active++;
				if (r.is_dense)
					res.initial_phase = PHASE_FACTORIZE;
				else if (r.push_only)
					res.initial_phase = PHASE_PARENT_WAIT;
				else
					res.initial_phase = PHASE_ASSEMBLE;
			end
		end else if (slot_of_id[r.item_id] != EMPTY_SLOT) begin
			pos = slot_of_id[r.item_id];
			res.slot = pos[SLOT_W-1:0];
			if (!r.push_only && !r.transfer_done) begin
				res.accepted = 1'b0;
			end else begin
				n_active--;
				if (n_active > 0) begin
					mover = id_at_slot[n_active];
					id_at_slot[pos] = mover;
					slot_of_id[mover] = pos;
				end
				slot_of_id[r.item_id] = EMPTY_SLOT;
			end
		end
		res.active_count = COUNT_W'(n_active);
		return res;
	endfunction

	// one transaction on the request channel; tvalid stays high afterwards
	task automatic send_req(input logic act, input logic [ID_W-1:0] id,
			input logic dense, input logic push, input logic xfer);
		set_req_t r;
		r = '{act, id, dense, push, xfer};
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b000, xfer, push, dense, id};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(apply_set_op(r));
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	function automatic logic [ID_W-1:0] pick_inactive_id();
		logic [ID_W-1:0] id;
		do
			id = ID_W'($urandom_range(NUM_IDS - 1));
		while (slot_of_id[id] != EMPTY_SLOT);
		return id;
	endfunction

	task automatic send_random_op(input int act_pct);
		logic act;
		logic [ID_W-1:0] id;
		int roll;
		act = ($urandom_range(99) < act_pct) ? ACT_ACTIVATE : ACT_FINISH;
		roll = $urandom_range(99);
		id = ID_W'($urandom_range(NUM_IDS - 1));
		if (act == ACT_ACTIVATE) begin
			if (roll < 85 && n_active < NUM_IDS)
				id = pick_inactive_id();
			else if (roll < 95 && n_active > 0)
				id = id_at_slot[$urandom_range(n_active - 1)];
		end else if (roll < 80 && n_active > 0) begin
			id = id_at_slot[$urandom_range(n_active - 1)];
		end
		send_req(act, id, 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endtask

	task automatic test_directed();
		set_idling(0, 0);
		send_req(ACT_FINISH, 10'h000, 1'b0, 1'b0, 1'b0);   // empty set
		send_req(ACT_ACTIVATE, 10'h000, 1'b1, 1'b1, 1'b0); // dense beats push-only
		send_req(ACT_ACTIVATE, 10'h3FF, 1'b0, 1'b1, 1'b0);
		send_req(ACT_ACTIVATE, 10'h155, 1'b0, 1'b0, 1'b1);
		send_req(ACT_ACTIVATE, 10'h2AA, 1'b1, 1'b0, 1'b1);
		send_req(ACT_ACTIVATE, 10'h3FF, 1'b1, 1'b0, 1'b1); // already active
		wait_results_drained();
		send_req(ACT_FINISH, 10'h155, 1'b1, 1'b0, 1'b0);   // transfer pending
		send_req(ACT_FINISH, 10'h155, 1'b0, 1'b0, 1'b1);   // last slot moves down
		send_req(ACT_FINISH, 10'h3FF, 1'b0, 1'b1, 1'b0);   // push-only ignores transfer
		send_req(ACT_ACTIVATE, 10'h2AA, 1'b0, 1'b0, 1'b0);
		send_req(ACT_FINISH, 10'h3FF, 1'b0, 1'b1, 1'b1);   // no longer active
		send_req(ACT_FINISH, 10'h000, 1'b1, 1'b1, 1'b1);
		send_req(ACT_FINISH, 10'h2AA, 1'b0, 1'b0, 1'b1);   // set empties
		send_req(ACT_ACTIVATE, 10'h200, 1'b1, 1'b1, 1'b1);
		send_req(ACT_FINISH, 10'h200, 1'b1, 1'b0, 1'b0);
		send_req(ACT_FINISH, 10'h200, 1'b0, 1'b1, 1'b1);   // only entry is the last
		wait_results_drained();
	endtask

	task automatic test_churn(input int send_pct, input int recv_pct, input int n_ops);
		set_idling(send_pct, recv_pct);
		repeat (n_ops)
			send_random_op(45);
		wait_results_drained();
	endtask

	task automatic test_fill();
		set_idling(0, 0);
		while (n_active < NUM_IDS)
			send_req(ACT_ACTIVATE, pick_inactive_id(), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		send_random_op(100);
		repeat (8)
			send_random_op(0);
		wait_results_drained();
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		set_result_t got;
		set_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[0], m_tdata[2:1], m_tdata[12:3], m_tdata[23:13]};
			if (pending_results.size() == 0) begin
				$error("result transaction with none outstanding: %h", m_tdata);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("accepted", want.accepted, got.accepted);
				check_field("initial_phase", want.initial_phase, got.initial_phase);
				check_field("slot", want.slot, got.slot);
				check_field("active_count", want.active_count, got.active_count);
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_IDS; i++) begin
			slot_of_id[i] = EMPTY_SLOT;
			id_at_slot[i] = '0;
		end
		n_active = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_churn(77, 0, 80);
		test_churn(0, 77, 80);
		test_churn(29, 29, 80);
		test_fill();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb_active_set_swap_remove: clean");
		else
			$display("tb_active_set_swap_remove: errors");
		$finish;
	end

endmodule

// ===== active_set_swap_remove.f =====
hw/rtl/asr_pkg.sv
hw/rtl/asr_ctrl.sv
hw/rtl/asr_dp.sv
hw/rtl/active_set_swap_remove.sv
tb/sv/tb_active_set_swap_remove.sv
